[hdl/fcp_pkg.sv]
// fcp_pkg: shared types and constants for the framed coordinate parser
// used by fcp_front, fcp_queue, fcp_back and framed_coordinate_parser
// no dependencies
package fcp_pkg;

	localparam logic [7:0] START_MARK = 8'h61;   // 'a'
	localparam logic [7:0] END_MARK   = 8'h7A;   // 'z'
	localparam logic [7:0] SPACE_CHAR = 8'h20;   // ' '
	localparam logic [7:0] ZERO_CHAR  = 8'h30;   // '0'

	// frame positions that feed a coordinate: 0..2 for x, 4..6 for y
	localparam int DIGIT_SLOTS = 6;
	localparam int READ_SPAN   = 7;
	localparam int GAP_POS     = 3;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// characters of one finished frame: x digits in slots 0..2, y digits in 3..5
	typedef logic [DIGIT_SLOTS-1:0][7:0] frame_chars_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic [QCNT_W-1:0] level;
	} q_status_t;

endpackage

[hdl/framed_coordinate_parser.sv]
// framed_coordinate_parser: top level, front parser, snapshot queue and converter
// depends on fcp_pkg, fcp_front, fcp_queue, fcp_back
//
// Usage:
//  s_axis carries one received ASCII byte per item in tdata[7:0].
//  'a' opens a frame and clears the stored characters; bytes that follow are
//  stored in order, and bytes past FRAME_BYTES are dropped. 'z' closes the
//  frame and yields one m_axis item: tdata[15:0] is coord_x (positions 0..2)
//  and tdata[31:16] is coord_y (positions 4..6), both signed decimal values
//  with a space read as '0'. A 'z' outside a frame reports the current store.
//  Throughput is one byte per cycle while the queue is not full. m_axis_tvalid
//  rises after its 'z' is accepted: the snapshot is first written into the
//  two-entry queue and is then loaded into the output register of the converter.
//  When the receiver stalls, results pile up in the queue; s_axis_tready
//  drops only while the queue is full, and bytes are then held off.
//  Reset clears the frame flag, write position and stored characters and
//  empties the queue and output register; no clearing pass is needed.
module framed_coordinate_parser #(
	parameter int FRAME_BYTES = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [15:0] coord_x, [31:16] coord_y
);

	logic                  push;
	logic                  pop;
	fcp_pkg::frame_chars_t push_chars;
	fcp_pkg::frame_chars_t head_chars;
	fcp_pkg::q_status_t    q_stat;
	logic signed [15:0]    coord_x;
	logic signed [15:0]    coord_y;

	fcp_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.push      (push),
		.push_chars(push_chars),
		.q_stat    (q_stat)
	);

	fcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_chars(push_chars),
		.pop       (pop),
		.head_chars(head_chars),
		.stat      (q_stat)
	);

	fcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_chars(head_chars),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.coord_x   (coord_x),
		.coord_y   (coord_y)
	);

	assign m_axis_tdata = {coord_y, coord_x};

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("snapshot pushed into a full queue");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level <= fcp_pkg::QCNT_W'(fcp_pkg::QDEPTH))
		else $error("queue level above depth");

	a_end_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tdata == fcp_pkg::END_MARK)
		|=> !q_stat.empty)
		else $error("end marker left no queued result");

	a_pop_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_axis_tvalid)
		else $error("popped snapshot did not reach the output");

endmodule

[hdl/fcp_front.sv]
// fcp_front: accepts serial bytes, tracks the frame and keeps the digit characters
// pushes one frame snapshot into the queue per end marker
// depends on fcp_pkg
module fcp_front #(
	parameter int FRAME_BYTES = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	output logic                push,
	output fcp_pkg::frame_chars_t push_chars,
	input  fcp_pkg::q_status_t  q_stat
);

	localparam int POS_W = $clog2(FRAME_BYTES + 1);

	logic                  receiving_q;
	logic [POS_W-1:0]      pos_q;
	fcp_pkg::frame_chars_t chars_q;
	logic                  accept;
	logic                  is_start;
	logic                  is_end;
	logic                  slot_hit;
	logic [2:0]            slot;

	assign in_ready   = !q_stat.full;
	assign accept     = in_valid && in_ready;
	assign is_start   = (in_byte == fcp_pkg::START_MARK);
	assign is_end     = (in_byte == fcp_pkg::END_MARK);
	assign push       = accept && is_end;
	assign push_chars = chars_q;

	// position 3 and positions past 6 are never read, so they are not kept
	always_comb begin
		slot_hit = (pos_q < POS_W'(fcp_pkg::READ_SPAN)) && (pos_q != POS_W'(fcp_pkg::GAP_POS));
		if (pos_q < POS_W'(fcp_pkg::GAP_POS)) begin
			slot = pos_q[2:0];
		end else begin
			slot = pos_q[2:0] - 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			pos_q       <= '0;
			chars_q     <= '0;
		end else if (accept) begin
			if (is_start) begin
				receiving_q <= 1'b1;
				pos_q       <= '0;
				chars_q     <= '0;
			end else if (is_end) begin
				receiving_q <= 1'b0;
			end else if (receiving_q && (pos_q < POS_W'(FRAME_BYTES))) begin
				pos_q <= pos_q + POS_W'(1);
				if (slot_hit) begin
					chars_q[slot] <= in_byte;
				end
			end
		end
	end

endmodule

[hdl/fcp_queue.sv]
// fcp_queue: two-entry queue of frame snapshots between front and back
// depends on fcp_pkg
module fcp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  fcp_pkg::frame_chars_t push_chars,
	input  logic                  pop,
	output fcp_pkg::frame_chars_t head_chars,
	output fcp_pkg::q_status_t    stat
);

	fcp_pkg::frame_chars_t           mem [fcp_pkg::QDEPTH];
	logic [fcp_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [fcp_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [fcp_pkg::QCNT_W-1:0]      level_q;

	assign stat.level = level_q;
	assign stat.empty = (level_q == '0);
	assign stat.full  = (level_q == fcp_pkg::QCNT_W'(fcp_pkg::QDEPTH));
	assign head_chars = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_chars;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + fcp_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + fcp_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + fcp_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - fcp_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

[hdl/fcp_back.sv]
// fcp_back: converts a queued frame into the x and y coordinates
// holds the result in an output register until the receiver takes it
// depends on fcp_pkg
module fcp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fcp_pkg::frame_chars_t head_chars,
	input  fcp_pkg::q_status_t    q_stat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    coord_x,
	output logic signed [15:0]    coord_y
);

	logic                valid_q;
	logic signed [15:0]  x_q;
	logic signed [15:0]  y_q;
	logic signed [15:0]  x_next;
	logic signed [15:0]  y_next;

	// a space reads as '0', anything else as its code minus '0'
	function automatic logic signed [15:0] digit_of(input logic [7:0] c);
		logic [7:0] cc;
		cc = (c == fcp_pkg::SPACE_CHAR) ? fcp_pkg::ZERO_CHAR : c;
		return $signed({8'd0, cc}) - $signed({8'd0, fcp_pkg::ZERO_CHAR});
	endfunction

	function automatic logic signed [15:0] three_digits(input logic [7:0] c0,
			input logic [7:0] c1, input logic [7:0] c2);
		return digit_of(c0) * 16'sd100 + digit_of(c1) * 16'sd10 + digit_of(c2);
	endfunction

	assign x_next    = three_digits(head_chars[0], head_chars[1], head_chars[2]);
	assign y_next    = three_digits(head_chars[3], head_chars[4], head_chars[5]);
	assign pop       = !q_stat.empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign coord_x   = x_q;
	assign coord_y   = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q <= x_next;
			y_q <= y_next;
		end
	end

endmodule

[sim/framed_coordinate_parser_chk.sv]
`timescale 1ns / 100ps
// framed_coordinate_parser_chk: watches both streams of the parser, predicts each
// coordinate pair from the accepted bytes and compares it with the output items
// depends on fcp_pkg
module framed_coordinate_parser_chk
	import fcp_pkg::*;
#(
	parameter int FRAME_BYTES = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // [15:0] coord_x, [31:16] coord_y
	output int          mismatches,
	output int          pending,
	output int          checked
);

	localparam int RADIX   = 10;
	localparam int Y_FIRST = GAP_POS + 1;

	typedef struct packed {
		logic signed [15:0] y;
		logic signed [15:0] x;
	} coord_pair_t;

	coord_pair_t expected_coords[$];
	coord_pair_t got_pair;
	coord_pair_t want_pair;

	logic       in_frame;
	int         next_pos;
	logic [7:0] stash [FRAME_BYTES];

	// a space reads as '0'; anything else is its code minus '0', unchecked
	function automatic int char_digit(logic [7:0] c);
		if (c == SPACE_CHAR)
			return 0;
		return int'(c) - int'(ZERO_CHAR);
	endfunction

	function automatic logic signed [15:0] decimal3(int first);
		int v;
		v = char_digit(stash[first]);
		v = v * RADIX + char_digit(stash[first + 1]);
		v = v * RADIX + char_digit(stash[first + 2]);
		return 16'(v);
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at result %0d: %s", checked, msg);
		mismatches++;
	endtask

	task automatic absorb_byte(logic [7:0] b);
		coord_pair_t pair;
		if (b == START_MARK) begin
			in_frame = 1'b1;
			next_pos = 0;
			foreach (stash[i])
				stash[i] = '0;
		end else begin
			if (b == END_MARK) begin
				in_frame = 1'b0;
				pair.x = decimal3(0);
				pair.y = decimal3(Y_FIRST);
				expected_coords.push_back(pair);
			end
			// bytes past the end of the store are dropped
			if (in_frame && next_pos < FRAME_BYTES) begin
				stash[next_pos] = b;
				next_pos++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame = 1'b0;
			next_pos = 0;
			foreach (stash[i])
				stash[i] = '0;
			expected_coords.delete();
			mismatches = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_pair = coord_pair_t'(m_axis_tdata);
				if (expected_coords.size() == 0) begin
					report_mismatch($sformatf("unexpected item x=%0d y=%0d",
						got_pair.x, got_pair.y));
				end else begin
					want_pair = expected_coords.pop_front();
					if (got_pair.x !== want_pair.x)
						report_mismatch($sformatf("coord_x got %0d expected %0d",
							got_pair.x, want_pair.x));
					if (got_pair.y !== want_pair.y)
						report_mismatch($sformatf("coord_y got %0d expected %0d",
							got_pair.y, want_pair.y));
					checked++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				absorb_byte(s_axis_tdata);
			pending = expected_coords.size();
		end
	end

endmodule

[sim/framed_coordinate_parser_tb.sv]
`timescale 1ns / 100ps
// framed_coordinate_parser_tb: drives framed byte streams into the parser with random
// gaps and output stalls, one long output hold-off included, and gives the verdict
// depends on fcp_pkg, framed_coordinate_parser, framed_coordinate_parser_chk
module framed_coordinate_parser_tb;
	import fcp_pkg::*;

	localparam int FRAME_BYTES  = 11;
	localparam int TARGET_BYTES = 700;
	localparam int MAX_GAP      = 19;
	localparam int HOLD_AFTER   = 20;
	localparam int HOLD_CYCLES  = 1200;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	int mismatches;
	int pending;
	int checked;
	int bytes_counted = 0;
	int frames_sent = 0;
	int tx_burst = 0;
	int rx_burst = 0;
	int rx_gap;
	int rx_taken = 0;
	int idle_cycles = 0;
	int input_stalls = 0;
	int kind;
	bit hold_done = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	framed_coordinate_parser #(
		.FRAME_BYTES(FRAME_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	framed_coordinate_parser_chk #(
		.FRAME_BYTES(FRAME_BYTES)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.mismatches(mismatches),
		.pending(pending),
		.checked(checked)
	);

	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = (tx_burst > 0) ? 0 : $urandom_range(0, MAX_GAP);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// mostly digits and spaces, now and then any byte at all
	function automatic logic [7:0] frame_char();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return ZERO_CHAR + 8'($urandom_range(0, 9));
		else if (pick == 6)
			return SPACE_CHAR;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_frame(bit closed, int len);
		send_byte(START_MARK);
		for (int i = 0; i < len; i++)
			send_byte(frame_char());
		if (closed)
			send_byte(END_MARK);
		bytes_counted += len + 1 + int'(closed);
		frames_sent++;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// close with no frame open: reads the cleared store
		send_byte(END_MARK);
		// ignored, no frame open
		send_byte(8'h00);
		send_byte(START_MARK);
		send_text("1 3x456");
		send_byte(END_MARK);
		// second start inside a frame reopens it; bytes past the store are dropped
		send_byte(START_MARK);
		send_byte(START_MARK);
		repeat (7) send_byte(8'hFF);
		repeat (4) send_byte(8'h00);
		send_text("qr");
		send_byte(END_MARK);
		bytes_counted += 27;
		frames_sent += 3;

		while (bytes_counted < TARGET_BYTES) begin
			if ($urandom_range(0, 7) == 0)
				tx_burst = $urandom_range(1, 4);
			else if (tx_burst > 0)
				tx_burst--;
			kind = $urandom_range(0, 19);
			if (kind < 15)
				send_frame(1'b1, ($urandom_range(0, 9) < 7) ?
					$urandom_range(7, FRAME_BYTES) : $urandom_range(0, FRAME_BYTES + 4));
			else if (kind < 17)
				send_frame(1'b0, $urandom_range(0, FRAME_BYTES + 4));
			else if (kind == 17) begin
				send_byte(END_MARK);
				bytes_counted++;
			end else begin
				send_byte(8'($urandom_range(0, 255)));
				bytes_counted++;
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d bytes in %0d frames, %0d coordinate pairs checked",
			bytes_counted, frames_sent, checked);
		$display("output held off %0d cycles once; input stalled for %0d cycles in all",
			HOLD_CYCLES, input_stalls);
		if (mismatches == 0)
			$display("framed_coordinate_parser_tb passed");
		else
			$display("framed_coordinate_parser_tb failed");
		$finish;
	end

	// receiver: random stalls, bursts of full readiness, one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			if (!hold_done && rx_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (rx_burst > 0) begin
				rx_gap = 0;
				rx_burst--;
			end else begin
				rx_gap = $urandom_range(0, MAX_GAP);
				if ($urandom_range(0, 7) == 0)
					rx_burst = $urandom_range(4, 16);
			end
			repeat (rx_gap) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			rx_taken++;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (s_axis_tvalid && !s_axis_tready)
				input_stalls++;
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
		$display("framed_coordinate_parser_tb failed");
		$finish;
	end

endmodule
